// ===== rtl/lmtc_pkg.sv =====
// Types, timing constants and enable bit indices for the LCD mode timing controller.
package lmtc_pkg;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_HBLANK = 2'd0;
   localparam mode_type MODE_VBLANK = 2'd1;
   localparam mode_type MODE_OAM    = 2'd2;
   localparam mode_type MODE_DRAW   = 2'd3;

   localparam logic [8:0] OAM_DOTS   = 9'd80;
   localparam logic [8:0] HBLANK_END = 9'd376;
   localparam logic [8:0] LINE_DOTS  = 9'd456;

   localparam logic [7:0] DRAW_COLS         = 8'd160;
   localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
   localparam logic [7:0] LINES_PER_FRAME   = 8'd154;

   localparam int unsigned EN_HBLANK_BIT = 0;
   localparam int unsigned EN_VBLANK_BIT = 1;
   localparam int unsigned EN_OAM_BIT    = 2;
   localparam int unsigned EN_MATCH_BIT  = 3;

endpackage

// ===== rtl/lcd_mode_timing_controller_core.sv =====
// LCD dot sequencer: mode, line counter, line compare, interrupts, pixel and OAM strobes.
//
// Each request transfer is one dot tick; ticks with advance or lcd_on low leave the
// timing state untouched and return the current mode, line and compare flag. Every
// tick yields exactly one response in a registered output, and a new tick is taken
// every clock while no response is pending or rsp_ready is high: the mode, dot, line
// and column counters update in one pass of short compare-and-increment logic into a
// single response register. A line runs 80 dots of OAM scan, 160 dots of drawing and
// horizontal blank up to mode dot 376; lines 144 to 153 are vertical blank, 456 dots
// each. Reset puts the sequencer at line 0, OAM scan, dot 0.
module lcd_mode_timing_controller_core
   import lmtc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_advance,
   input  logic       req_lcd_on,
   input  logic [7:0] req_lyc,
   input  logic [3:0] req_stat_enables,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_lcd_mode,
   output logic [7:0] rsp_line,
   output logic       rsp_line_match,
   output logic       rsp_stat_irq,
   output logic       rsp_vblank_irq,
   output logic       rsp_pixel_valid,
   output logic [7:0] rsp_pixel_x,
   output logic       rsp_oam_probe_valid,
   output logic [5:0] rsp_oam_slot
);

   mode_type   mode_ff, mode_in;
   logic [8:0] dot_ff, dot_in;
   logic [7:0] line_ff, line_in;
   logic [7:0] col_ff, col_in;
   logic       match_ff, match_in;
   logic       rsp_valid_ff;

   logic [8:0] dot_inc;
   logic [7:0] line_inc;
   logic [7:0] col_inc;
   logic       stat_in, vblank_in, pix_v_in, probe_v_in;
   logic [7:0] pix_x_in;
   logic [5:0] slot_in;

   logic       req_fire;
   logic       tick;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign tick      = req_advance && req_lcd_on;
   assign dot_inc   = dot_ff + 9'd1;
   assign line_inc  = line_ff + 8'd1;
   assign col_inc   = col_ff + 8'd1;

   always_comb begin
      mode_in    = mode_ff;
      dot_in     = dot_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      match_in   = match_ff;
      stat_in    = 1'b0;
      vblank_in  = 1'b0;
      pix_v_in   = 1'b0;
      pix_x_in   = 8'd0;
      probe_v_in = 1'b0;
      slot_in    = 6'd0;
      if (tick) begin
         case (mode_ff)
            MODE_HBLANK: begin
               dot_in = dot_inc;
               if (dot_inc >= HBLANK_END) begin
                  line_in  = line_inc;
                  dot_in   = 9'd0;
                  col_in   = 8'd0;
                  match_in = (req_lyc == line_inc);
                  stat_in  = match_in && req_stat_enables[EN_MATCH_BIT];
                  if (line_inc >= FIRST_VBLANK_LINE) begin
                     mode_in   = MODE_VBLANK;
                     vblank_in = 1'b1;
                     if (req_stat_enables[EN_VBLANK_BIT]) stat_in = 1'b1;
                  end else begin
                     mode_in = MODE_OAM;
                     if (req_stat_enables[EN_OAM_BIT]) stat_in = 1'b1;
                  end
               end
            end
            MODE_VBLANK: begin
               dot_in = dot_inc;
               if (dot_inc >= LINE_DOTS) begin
                  dot_in  = 9'd0;
                  line_in = line_inc;
                  if (line_inc >= LINES_PER_FRAME) begin
                     line_in = 8'd0;
                     mode_in = MODE_OAM;
                     if (req_stat_enables[EN_OAM_BIT]) stat_in = 1'b1;
                  end
                  match_in = (req_lyc == line_in);
                  if (match_in && req_stat_enables[EN_MATCH_BIT]) stat_in = 1'b1;
               end
            end
            MODE_OAM: begin
               if (!dot_ff[0]) begin
                  probe_v_in = 1'b1;
                  slot_in    = dot_ff[6:1];
               end
               dot_in = dot_inc;
               if (dot_inc >= OAM_DOTS) begin
                  dot_in  = 9'd0;
                  mode_in = MODE_DRAW;
               end
            end
            default: begin
               dot_in   = dot_inc;
               pix_v_in = 1'b1;
               pix_x_in = col_ff;
               col_in   = col_inc;
               if (col_inc >= DRAW_COLS) begin
                  mode_in = MODE_HBLANK;
                  if (req_stat_enables[EN_HBLANK_BIT]) stat_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OAM;
         dot_ff       <= 9'd0;
         line_ff      <= 8'd0;
         col_ff       <= 8'd0;
         match_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            mode_ff  <= mode_in;
            dot_ff   <= dot_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            match_ff <= match_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_lcd_mode        <= mode_in;
         rsp_line            <= line_in;
         rsp_line_match      <= match_in;
         rsp_stat_irq        <= stat_in;
         rsp_vblank_irq      <= vblank_in;
         rsp_pixel_valid     <= pix_v_in;
         rsp_pixel_x         <= pix_x_in;
         rsp_oam_probe_valid <= probe_v_in;
         rsp_oam_slot        <= slot_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_vblank_line: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_VBLANK |-> line_ff >= FIRST_VBLANK_LINE)
      else $error("vblank mode outside vblank lines");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      req_fire && !tick |=> $stable(mode_ff) && $stable(dot_ff) && $stable(line_ff))
      else $error("timing state moved on a held dot");

   a_vblank_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vblank_irq |-> rsp_line == FIRST_VBLANK_LINE
                                       && rsp_lcd_mode == MODE_VBLANK)
      else $error("vblank pulse away from frame end");

   a_pixel_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_valid |-> rsp_lcd_mode == MODE_DRAW
                                       || rsp_lcd_mode == MODE_HBLANK)
      else $error("pixel strobe outside drawing");

endmodule
